// ===== sv/mliq_pkg.sv =====
// Package for the multimode logic input qualifier.
// Holds widths, register indexes, mode codes and the evaluation result type.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none

package mliq_pkg;

  // Sample width in bits (Q16.16 at 32); thresholds are fixed at 32 bits.
  localparam int SAMPLE_WIDTH = 32;
  localparam int THRESH_WIDTH = 32;
  localparam int CFG_WIDTH    = 32;
  localparam int CFG_IDX_W    = 2;

  // Compare width: room for the difference of two samples and a negated threshold.
  localparam int CMP_WIDTH =
    ((SAMPLE_WIDTH > THRESH_WIDTH) ? SAMPLE_WIDTH : THRESH_WIDTH) + 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MODE      = 2'd0;
  localparam cfg_idx_t REG_HIGH_THR  = 2'd1;
  localparam cfg_idx_t REG_LOW_THR   = 2'd2;
  localparam cfg_idx_t REG_INVERT    = 2'd3;

  typedef enum logic [2:0] {
    MODE_LEVEL         = 3'd0,
    MODE_RISE          = 3'd1,
    MODE_FALL          = 3'd2,
    MODE_BOTH          = 3'd3,
    MODE_SCHMITT       = 3'd4,
    MODE_SCHMITT_PULSE = 3'd5
  } mode_t;

  // Result of one evaluation: the qualified bit and the level to hold.
  typedef struct packed {
    logic result;
    logic held_next;
  } eval_t;

endpackage

`default_nettype wire

// ===== sv/mliq_eval.sv =====
// Combinational rule evaluation for one sample of the logic input qualifier.
// Compares the sample and its difference to the thresholds per mode.
// Depends on mliq_pkg.
`default_nettype none

module mliq_eval (
  input  wire logic                                   [2:0] mode,
  input  wire logic signed [mliq_pkg::SAMPLE_WIDTH-1:0]     sample,
  input  wire logic signed [mliq_pkg::SAMPLE_WIDTH-1:0]     previous_sample,
  input  wire logic signed [mliq_pkg::THRESH_WIDTH-1:0]     high_threshold,
  input  wire logic signed [mliq_pkg::THRESH_WIDTH-1:0]     low_threshold,
  input  wire logic                                         invert,
  input  wire logic                                         held_level,
  output mliq_pkg::eval_t                                   eval
);

  localparam int CW = mliq_pkg::CMP_WIDTH;
  localparam int SW = mliq_pkg::SAMPLE_WIDTH;
  localparam int TW = mliq_pkg::THRESH_WIDTH;

  logic signed [CW-1:0] s_ext;
  logic signed [CW-1:0] p_ext;
  logic signed [CW-1:0] h_ext;
  logic signed [CW-1:0] l_ext;
  logic signed [CW-1:0] h_neg;
  logic signed [CW-1:0] diff;
  logic signed [CW-1:0] diff_abs;
  logic                 ge_high;
  logic                 lt_low;
  logic                 r;
  logic                 held_next;

  // Widen everything so no difference or negation wraps.
  assign s_ext    = {{(CW-SW){sample[SW-1]}}, sample};
  assign p_ext    = {{(CW-SW){previous_sample[SW-1]}}, previous_sample};
  assign h_ext    = {{(CW-TW){high_threshold[TW-1]}}, high_threshold};
  assign l_ext    = {{(CW-TW){low_threshold[TW-1]}}, low_threshold};
  assign h_neg    = -h_ext;
  assign diff     = s_ext - p_ext;
  assign diff_abs = diff[CW-1] ? -diff : diff;
  assign ge_high  = (s_ext >= h_ext);
  assign lt_low   = (s_ext < l_ext);

  always_comb begin
    r         = 1'b0;
    held_next = 1'b0;
    case (mode)
      mliq_pkg::MODE_LEVEL: begin
        r         = ge_high;
        held_next = r;
      end
      mliq_pkg::MODE_RISE: begin
        r         = (diff >= h_ext);
        held_next = r;
      end
      mliq_pkg::MODE_FALL: begin
        r         = (diff <= h_neg);
        held_next = r;
      end
      mliq_pkg::MODE_BOTH: begin
        r         = (diff_abs >= h_ext);
        held_next = r;
      end
      mliq_pkg::MODE_SCHMITT: begin
        // High test wins when the thresholds are crossed.
        if (ge_high) begin
          r = 1'b1;
        end else if (lt_low) begin
          r = 1'b0;
        end else begin
          r = held_level;
        end
        held_next = r;
      end
      mliq_pkg::MODE_SCHMITT_PULSE: begin
        if (ge_high) begin
          r         = ~held_level;
          held_next = 1'b1;
        end else if (lt_low) begin
          held_next = 1'b0;
        end else begin
          held_next = held_level;
        end
      end
      default: begin
        r         = 1'b0;
        held_next = 1'b0;
      end
    endcase
  end

  assign eval.result    = r ^ invert;
  assign eval.held_next = held_next;

endmodule

`default_nettype wire

// ===== sv/multimode_logic_input_qualifier_unit.sv =====
// Top level of the multimode logic input qualifier (Schmitt trigger / edge detector).
// Input register, rule evaluation, result register and the config registers.
// Depends on mliq_pkg and mliq_eval.
`default_nettype none

//  channel | signals                          | beat
//  --------+----------------------------------+------------------------------------
//  in      | in_valid, in_ready, sample       | one signed sample
//  out     | out_valid, out_ready, logic_out  | one qualified logic bit per sample
//  cfg     | cfg_we, cfg_index, cfg_data      | one register write, no handshake
//
// One beat per clock in and out unless the output stalls: a sample goes from the
// input register through the compare logic into the result register, with a single
// evaluation between those two registers.
// Reset (rst, synchronous) empties both registers and clears the config registers,
// the previous sample and the held level.
// A stalled output holds its result; the input register keeps taking beats while
// either the input register or the result register has room.

module multimode_logic_input_qualifier_unit (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  // Configuration
  input  wire logic                                         cfg_we,
  input  wire logic [mliq_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  wire logic [mliq_pkg::CFG_WIDTH-1:0]               cfg_data,
  // Sample in
  input  wire logic                                         in_valid,
  output logic                                              in_ready,
  input  wire logic signed [mliq_pkg::SAMPLE_WIDTH-1:0]     sample,
  // Result out
  output logic                                              out_valid,
  input  wire logic                                         out_ready,
  output logic                                              logic_out
);

  localparam int SW = mliq_pkg::SAMPLE_WIDTH;
  localparam int TW = mliq_pkg::THRESH_WIDTH;

  // Config registers
  logic        [2:0]    mode;
  logic signed [TW-1:0] high_threshold;
  logic signed [TW-1:0] low_threshold;
  logic                 invert;

  // Input register
  logic                 in_reg_valid;
  logic signed [SW-1:0] in_reg_sample;

  // State carried from item to item
  logic signed [SW-1:0] previous_sample;
  logic                 held_level;

  mliq_pkg::eval_t      eval;
  logic                 advance;
  logic                 retire;

  // Result register moves when it is empty or being taken.
  assign advance  = ~out_valid | out_ready;
  assign retire   = in_reg_valid & advance;
  assign in_ready = ~in_reg_valid | advance;

  // Register writes; indexes beyond the list do not exist at this port width.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= 3'(mliq_pkg::MODE_LEVEL);
      high_threshold <= '0;
      low_threshold  <= '0;
      invert         <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mliq_pkg::REG_MODE:     mode           <= cfg_data[2:0];
        mliq_pkg::REG_HIGH_THR: high_threshold <= signed'(cfg_data[TW-1:0]);
        mliq_pkg::REG_LOW_THR:  low_threshold  <= signed'(cfg_data[TW-1:0]);
        mliq_pkg::REG_INVERT:   invert         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture a beat whenever the input register has room.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg_sample <= sample;
    end
  end

  mliq_eval u_eval (
    .mode            (mode),
    .sample          (in_reg_sample),
    .previous_sample (previous_sample),
    .high_threshold  (high_threshold),
    .low_threshold   (low_threshold),
    .invert          (invert),
    .held_level      (held_level),
    .eval            (eval)
  );

  // Advance the state only when a sample moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      held_level      <= 1'b0;
    end else if (retire) begin
      previous_sample <= in_reg_sample;
      held_level      <= eval.held_next;
    end
  end

  // Result register: fill on retire, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      logic_out <= eval.result;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mliq_checker.sv =====
// Port-level checker for the multimode logic input qualifier, with its bind.
// Watches the in and out handshakes of the top level over time.
// Depends on multimode_logic_input_qualifier_unit.
`default_nettype none

module mliq_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic logic_out
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(logic_out))
    else $error("result bit changed while stalled");

  // Input backpressure only comes from a stalled, full result register.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // An accepted sample reaches the output once the result register has room.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 (out_ready || !out_valid) |=> out_valid)
    else $error("accepted sample gave no result");

endmodule

bind multimode_logic_input_qualifier_unit mliq_checker u_mliq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .logic_out (logic_out)
);

`default_nettype wire

// ===== test/tb_multimode_logic_input_qualifier_unit.sv =====
// Testbench for multimode_logic_input_qualifier_unit: directed and random sample beats
// with a bit-accurate predictor and an in-order scoreboard on logic_out.
// Depends on mliq_pkg and the multimode_logic_input_qualifier_unit RTL.
`default_nettype none

typedef logic signed [mliq_pkg::SAMPLE_WIDTH-1:0] sample_t;
typedef logic signed [mliq_pkg::THRESH_WIDTH-1:0] thresh_t;

// Predicts the qualified bit of each accepted sample and matches results in order.
class qualifier_scoreboard;
  logic [2:0] mode;
  thresh_t    hi_thr;
  thresh_t    lo_thr;
  logic       inv;
  sample_t    last_sample;
  logic       held;
  logic       expected_bits[$];
  int         errors;

  function new();
    mode        = mliq_pkg::MODE_LEVEL;
    hi_thr      = '0;
    lo_thr      = '0;
    inv         = 1'b0;
    last_sample = '0;
    held        = 1'b0;
    errors      = 0;
  endfunction

  function void write_reg(mliq_pkg::cfg_idx_t idx, logic [mliq_pkg::CFG_WIDTH-1:0] data);
    case (idx)
      mliq_pkg::REG_MODE:     mode   = data[2:0];
      mliq_pkg::REG_HIGH_THR: hi_thr = data[mliq_pkg::THRESH_WIDTH-1:0];
      mliq_pkg::REG_LOW_THR:  lo_thr = data[mliq_pkg::THRESH_WIDTH-1:0];
      mliq_pkg::REG_INVERT:   inv    = data[0];
      default: ;
    endcase
  endfunction

  // Compare at CMP_WIDTH so the sample difference and the negated threshold never wrap.
  function void note_sample(sample_t s);
    logic signed [mliq_pkg::CMP_WIDTH-1:0] sx, px, hx, lx, diff, mag;
    logic r;
    sx   = s;
    px   = last_sample;
    hx   = hi_thr;
    lx   = lo_thr;
    diff = sx - px;
    mag  = (diff < 0) ? -diff : diff;
    case (mode)
      mliq_pkg::MODE_LEVEL: begin
        r    = (sx >= hx);
        held = r;
      end
      mliq_pkg::MODE_RISE: begin
        r    = (diff >= hx);
        held = r;
      end
      mliq_pkg::MODE_FALL: begin
        r    = (diff <= -hx);
        held = r;
      end
      mliq_pkg::MODE_BOTH: begin
        r    = (mag >= hx);
        held = r;
      end
      mliq_pkg::MODE_SCHMITT: begin
        if (sx >= hx) r = 1'b1;
        else if (sx < lx) r = 1'b0;
        else r = held;
        held = r;
      end
      mliq_pkg::MODE_SCHMITT_PULSE: begin
        r = 1'b0;
        if (sx >= hx) begin
          r    = !held;
          held = 1'b1;
        end else if (sx < lx) begin
          held = 1'b0;
        end
      end
      default: begin
        r    = 1'b0;
        held = 1'b0;
      end
    endcase
    expected_bits.push_back(r ^ inv);
    last_sample = s;
  endfunction

  function void check_result(logic got);
    logic want;
    if (expected_bits.size() == 0) begin
      $error("logic_out: result with no sample pending, got %0b", got);
      errors++;
      return;
    end
    want = expected_bits.pop_front();
    if (got !== want) begin
      $error("logic_out: expected %0b, actual %0b", want, got);
      errors++;
    end
  endfunction

  function int pending();
    return expected_bits.size();
  endfunction
endclass

module tb_multimode_logic_input_qualifier_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Mode codes the package leaves unnamed; both force a zero result before invert and clear the hold.
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam sample_t S_MIN = {1'b1, {(mliq_pkg::SAMPLE_WIDTH-1){1'b0}}};
  localparam sample_t S_MAX = {1'b0, {(mliq_pkg::SAMPLE_WIDTH-1){1'b1}}};
  localparam thresh_t T_MIN = {1'b1, {(mliq_pkg::THRESH_WIDTH-1){1'b0}}};
  localparam thresh_t T_MAX = {1'b0, {(mliq_pkg::THRESH_WIDTH-1){1'b1}}};
  localparam int      ONE   = 32'sh0001_0000;   // 1.0 in Q16.16

  localparam int RANDOM_PHASES = 17;
  localparam int PHASE_BEATS   = 25;
  localparam int SETTLE_CYCLES = 4;              // two-stage pipe plus margin

  logic clk;
  logic rst;
  logic cfg_we;
  mliq_pkg::cfg_idx_t cfg_index;
  logic [mliq_pkg::CFG_WIDTH-1:0] cfg_data;
  logic    in_valid;
  logic    in_ready;
  sample_t sample;
  logic    out_valid;
  logic    out_ready;
  logic    logic_out;

  qualifier_scoreboard sb;
  bit      quiet;        // when set, neither side inserts gaps
  sample_t last_sent;

  multimode_logic_input_qualifier_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .logic_out (logic_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic thresh_t pick_threshold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6)  return T_MIN;
    if (r < 12) return T_MAX;
    if (r < 16) return '0;
    if (r < 36) return thresh_t'($urandom());
    return thresh_t'(int'($urandom_range(0, 32'hA_0000)) - 32'sh5_0000);
  endfunction

  // Aim most samples near the decision points of the current mode so that each
  // compare lands on both sides and on equality; mix in extremes and noise.
  function automatic sample_t pick_sample(logic [2:0] m, thresh_t hi, thresh_t lo);
    int     r;
    longint anchor;
    longint offs;
    r = $urandom_range(0, 99);
    if (r < 4)  return S_MIN;
    if (r < 8)  return S_MAX;
    if (r < 10) return '0;
    if (r < 25) return sample_t'($urandom());
    if (m == mliq_pkg::MODE_RISE || m == mliq_pkg::MODE_FALL || m == mliq_pkg::MODE_BOTH)
      anchor = longint'(last_sent) + ($urandom_range(0, 1) ? longint'(hi) : -longint'(hi));
    else
      anchor = $urandom_range(0, 1) ? longint'(hi) : longint'(lo);
    if ($urandom_range(0, 1)) offs = longint'($urandom_range(0, 6)) - 3;
    else offs = longint'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
    return sample_t'(anchor + offs);
  endfunction

  // One register write per clock; hold the enable high across a burst of writes.
  task automatic cfg_write(mliq_pkg::cfg_idx_t idx, logic [mliq_pkg::CFG_WIDTH-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Drop valid, let every pending result drain and the pipe settle, then reprogram.
  task automatic program_config(logic [2:0] m, thresh_t hi, thresh_t lo, logic inv);
    logic [mliq_pkg::CFG_WIDTH-1:0] word;
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    // Upper bits of the narrow registers carry junk; only the low bits count.
    word      = $urandom();
    word[2:0] = m;
    cfg_write(mliq_pkg::REG_MODE, word);
    cfg_write(mliq_pkg::REG_HIGH_THR, hi);
    cfg_write(mliq_pkg::REG_LOW_THR, lo);
    word      = $urandom();
    word[0]   = inv;
    cfg_write(mliq_pkg::REG_INVERT, word);
    cfg_we <= 1'b0;
  endtask

  // Present one sample beat and hold it until accepted. Ready is looked at on the
  // falling edge, where nothing is changing, and the beat moves on the next rise.
  task automatic send_sample(sample_t s);
    int  gap;
    logic took;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    sb.note_sample(s);
    last_sent = s;
  endtask

  // Result side: stall at random, check every beat that moves.
  initial begin
    int stall;
    out_ready <= 1'b0;
    stall = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
      @(negedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) sb.check_result(logic_out);
      @(posedge clk);
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [2:0] m;
    thresh_t    hi;
    thresh_t    lo;
    sb        = new();
    quiet     = 1'b0;
    last_sent = '0;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= mliq_pkg::REG_MODE;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    sample    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Level at reset settings: field extremes and a sample exactly on the threshold.
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample('0);

    // Rise on a full-scale jump up and down: the difference must not wrap.
    program_config(mliq_pkg::MODE_RISE, ONE, '0, 1'b0);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(S_MIN);

    // Fall, inverted.
    program_config(mliq_pkg::MODE_FALL, ONE, '0, 1'b1);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MIN);

    // Either direction against the largest threshold.
    program_config(mliq_pkg::MODE_BOTH, T_MAX, T_MIN, 1'b0);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MAX);

    // Schmitt: set, hold inside the band, release, hold low.
    program_config(mliq_pkg::MODE_SCHMITT, 2 * ONE, -ONE, 1'b0);
    send_sample(2 * ONE);
    send_sample('0);
    send_sample(-2 * ONE);
    send_sample('0);

    // Rising pulse: fire once, stay quiet above, re-arm below the low threshold.
    program_config(mliq_pkg::MODE_SCHMITT_PULSE, ONE, '0, 1'b0);
    send_sample(2 * ONE);
    send_sample(3 * ONE);
    send_sample(-ONE);
    send_sample(2 * ONE);

    // Crossed thresholds: the high test wins.
    program_config(mliq_pkg::MODE_SCHMITT, '0, ONE, 1'b0);
    send_sample(ONE / 2);
    send_sample(-1);

    // Spare mode codes force zero and clear the hold; see it with and without invert.
    program_config(MODE_SPARE_LO, '0, '0, 1'b0);
    send_sample(S_MAX);
    program_config(MODE_SPARE_HI, '0, '0, 1'b1);
    send_sample(S_MAX);

    // Random settings, each followed by a burst aimed at its decision points.
    // The held level carries over from one setting to the next on purpose.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      m  = 3'($urandom_range(0, 7));
      hi = pick_threshold();
      if ($urandom_range(0, 99) < 80)
        lo = thresh_t'(longint'(hi) - longint'($urandom_range(0, 32'h6_0000)));
      else
        lo = pick_threshold();
      program_config(m, hi, lo, 1'($urandom_range(0, 1)));
      quiet = (ph % 4 == 3);
      for (int i = 0; i < PHASE_BEATS; i++) send_sample(pick_sample(m, hi, lo));
    end

    // Drain: wait for every expected bit, then a few more cycles for strays.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("logic_out: %0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
